// ===== rtl/pfmsi_pkg.sv =====
// shared constants, codes and controller/datapath link types for the modular arithmetic unit
package pfmsi_pkg;

    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned OPCODE_BITS = 2;
    localparam int unsigned CNT_W       = $clog2(WORD_BITS);

    localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] MOD_RESET = WORD_BITS'(64'd2381327587);

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_MUL  = 2'd0,
        OP_SQR  = 2'd1,
        OP_INV  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START_RED_A,
        CMD_START_RED_B,
        CMD_SAVE_A,
        CMD_SAVE_B,
        CMD_START_MUL_AB,
        CMD_START_MUL_AA,
        CMD_EU_INIT,
        CMD_START_EU,
        CMD_STEP_A,
        CMD_STEP_B,
        CMD_EU_UPDATE,
        CMD_RESULT
    } t_cmd;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ACC,
        SRC_T
    } t_src;

    typedef struct packed {
        t_cmd cmd;
        t_src src;
    } t_ctl;

    typedef struct packed {
        logic m_small;
        t_op  op;
        logic nr_zero;
    } t_sts;

endpackage

// ===== rtl/pfmsi_req_if.sv =====
// request channel: opcode and two operands with valid/ready
interface pfmsi_req_if;
    import pfmsi_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_BITS-1:0] opcode;
    logic [WORD_BITS-1:0]   operand_a;
    logic [WORD_BITS-1:0]   operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

// ===== rtl/pfmsi_rsp_if.sv =====
// response channel: one result word with valid/ready
interface pfmsi_rsp_if;
    import pfmsi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ===== rtl/pfmsi_dp.sv =====
// datapath: operand registers, shift-subtract divider, modular double-and-add, euclid state
module pfmsi_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pfmsi_pkg::t_ctl                i_ctl,
    input  logic [pfmsi_pkg::WORD_BITS-1:0]   i_modulus,
    input  logic [pfmsi_pkg::OPCODE_BITS-1:0] i_opcode,
    input  logic [pfmsi_pkg::WORD_BITS-1:0]   i_operand_a,
    input  logic [pfmsi_pkg::WORD_BITS-1:0]   i_operand_b,
    output pfmsi_pkg::t_sts                o_sts,
    output logic [pfmsi_pkg::WORD_BITS-1:0]   o_result
);
    import pfmsi_pkg::*;

    // (u + v) mod m for u, v below m
    function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] u,
                                                     input logic [WORD_BITS-1:0] v,
                                                     input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS:0] s;
        logic [WORD_BITS:0] d;
        s = {1'b0, u} + {1'b0, v};
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[WORD_BITS-1:0] : s[WORD_BITS-1:0];
    endfunction

    t_op                  r_op;
    logic [WORD_BITS-1:0] r_m;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_x;
    logic [WORD_BITS-1:0] r_dvd;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_dsr;
    logic [WORD_BITS-1:0] r_acc;
    logic                 r_qbit;
    logic                 r_mul;
    logic [WORD_BITS-1:0] r_r;
    logic [WORD_BITS-1:0] r_nr;
    logic [WORD_BITS-1:0] r_t;
    logic [WORD_BITS-1:0] r_nt;
    logic [WORD_BITS-1:0] r_res;

    logic [WORD_BITS:0]   rem2;
    logic [WORD_BITS:0]   rem_diff;
    logic                 rem_ge;
    logic [WORD_BITS-1:0] div_rem;
    logic [WORD_BITS-1:0] acc_dbl;
    logic [WORD_BITS-1:0] acc_add;
    logic [WORD_BITS:0]   t_diff;
    logic [WORD_BITS-1:0] t_new;

    // one restoring division step: shift in the next dividend bit
    assign rem2     = {r_rem, r_dvd[WORD_BITS-1]};
    assign rem_diff = rem2 - {1'b0, r_dsr};
    assign rem_ge   = (rem2 >= {1'b0, r_dsr});
    assign div_rem  = rem_ge ? rem_diff[WORD_BITS-1:0] : rem2[WORD_BITS-1:0];

    assign acc_dbl = add_mod(r_acc, r_acc, r_m);
    assign acc_add = add_mod(r_acc, r_x, r_m);

    // t - q*nt mod m, acc holds q*nt mod m
    assign t_diff = {1'b0, r_t} - {1'b0, r_acc};
    assign t_new  = t_diff[WORD_BITS] ? (t_diff[WORD_BITS-1:0] + r_m) : t_diff[WORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_LOAD: begin
                r_op <= t_op'(i_opcode);
                r_a  <= i_operand_a;
                r_b  <= i_operand_b;
                r_m  <= i_modulus;
            end
            CMD_START_RED_A: begin
                r_dvd <= r_a;
                r_rem <= '0;
                r_dsr <= r_m;
                r_mul <= 1'b0;
            end
            CMD_START_RED_B: begin
                r_dvd <= r_b;
                r_rem <= '0;
                r_dsr <= r_m;
                r_mul <= 1'b0;
            end
            CMD_SAVE_A: begin
                r_a <= r_rem;
            end
            CMD_SAVE_B: begin
                r_b <= r_rem;
            end
            CMD_START_MUL_AB: begin
                r_x   <= r_a;
                r_dvd <= r_b;
                r_acc <= '0;
                r_mul <= 1'b1;
            end
            CMD_START_MUL_AA: begin
                r_x   <= r_a;
                r_dvd <= r_a;
                r_acc <= '0;
                r_mul <= 1'b1;
            end
            CMD_EU_INIT: begin
                r_r  <= r_m;
                r_nr <= r_a;
                r_t  <= '0;
                r_nt <= WORD_BITS'(1);
            end
            CMD_START_EU: begin
                r_dvd <= r_r;
                r_rem <= '0;
                r_dsr <= r_nr;
                r_x   <= r_nt;
                r_acc <= '0;
                r_mul <= 1'b0;
            end
            CMD_STEP_A: begin
                r_dvd  <= {r_dvd[WORD_BITS-2:0], 1'b0};
                r_qbit <= r_mul ? r_dvd[WORD_BITS-1] : rem_ge;
                if (!r_mul) begin
                    r_rem <= div_rem;
                end
                r_acc <= acc_dbl;
            end
            CMD_STEP_B: begin
                if (r_qbit) begin
                    r_acc <= acc_add;
                end
            end
            CMD_EU_UPDATE: begin
                r_t  <= r_nt;
                r_nt <= t_new;
                r_r  <= r_nr;
                r_nr <= r_rem;
            end
            CMD_RESULT: begin
                case (i_ctl.src)
                    SRC_ACC: r_res <= r_acc;
                    SRC_T:   r_res <= r_t;
                    default: r_res <= '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_sts.m_small = (r_m[WORD_BITS-1:1] == '0);
    assign o_sts.op      = r_op;
    assign o_sts.nr_zero = (r_nr == '0);
    assign o_result      = r_res;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_ctl.cmd) == CMD_STEP_A) && !r_mul |-> (r_rem < r_dsr))
        else $error("partial remainder not below divisor");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_ctl.cmd) == CMD_STEP_B) |-> (r_acc < r_m))
        else $error("accumulator not reduced");

    a_coef_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_ctl.cmd) == CMD_EU_UPDATE) |-> ((r_t < r_m) && (r_nt < r_m)))
        else $error("euclid coefficient not reduced");

endmodule

// ===== rtl/pfmsi_ctrl.sv =====
// controller: sequences reductions, multiplies and euclid iterations, owns the result slot
module pfmsi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  logic            i_rsp_ready,
    output logic            o_rsp_valid,
    input  pfmsi_pkg::t_sts i_sts,
    output pfmsi_pkg::t_ctl o_ctl
);
    import pfmsi_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_START    = 8'b0000_0010,
        S_RUN_A    = 8'b0000_0100,
        S_RUN_B    = 8'b0000_1000,
        S_NEXT     = 8'b0001_0000,
        S_DISPATCH = 8'b0010_0000,
        S_EU_TEST  = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        JOB_RED_A,
        JOB_RED_B,
        JOB_MUL,
        JOB_EU
    } t_job;

    t_state           r_state, n_state;
    t_job             r_job, n_job;
    t_src             r_src, n_src;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_src       = r_src;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_ctl.cmd   = CMD_NONE;
        o_ctl.src   = r_src;

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = S_START;
                end
            end
            S_START: begin
                if (i_sts.m_small || (i_sts.op == OP_NONE)) begin
                    n_src   = SRC_ZERO;
                    n_state = S_FIN;
                end else begin
                    o_ctl.cmd = CMD_START_RED_A;
                    n_job     = JOB_RED_A;
                    n_cnt     = '0;
                    n_state   = S_RUN_A;
                end
            end
            S_RUN_A: begin
                o_ctl.cmd = CMD_STEP_A;
                if ((r_job == JOB_RED_A) || (r_job == JOB_RED_B)) begin
                    if (r_cnt == CNT_LAST) begin
                        n_state = S_NEXT;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    n_state = S_RUN_B;
                end
            end
            S_RUN_B: begin
                o_ctl.cmd = CMD_STEP_B;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_NEXT;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_RUN_A;
                end
            end
            S_NEXT: begin
                case (r_job)
                    JOB_RED_A: begin
                        o_ctl.cmd = CMD_SAVE_A;
                        n_state   = S_DISPATCH;
                    end
                    JOB_RED_B: begin
                        o_ctl.cmd = CMD_SAVE_B;
                        n_state   = S_DISPATCH;
                    end
                    JOB_MUL: begin
                        n_src   = SRC_ACC;
                        n_state = S_FIN;
                    end
                    default: begin
                        o_ctl.cmd = CMD_EU_UPDATE;
                        n_state   = S_EU_TEST;
                    end
                endcase
            end
            S_DISPATCH: begin
                n_cnt = '0;
                if (r_job == JOB_RED_A) begin
                    case (i_sts.op)
                        OP_MUL: begin
                            o_ctl.cmd = CMD_START_RED_B;
                            n_job     = JOB_RED_B;
                            n_state   = S_RUN_A;
                        end
                        OP_SQR: begin
                            o_ctl.cmd = CMD_START_MUL_AA;
                            n_job     = JOB_MUL;
                            n_state   = S_RUN_A;
                        end
                        default: begin
                            o_ctl.cmd = CMD_EU_INIT;
                            n_job     = JOB_EU;
                            n_state   = S_EU_TEST;
                        end
                    endcase
                end else begin
                    o_ctl.cmd = CMD_START_MUL_AB;
                    n_job     = JOB_MUL;
                    n_state   = S_RUN_A;
                end
            end
            S_EU_TEST: begin
                if (i_sts.nr_zero) begin
                    n_src   = SRC_T;
                    n_state = S_FIN;
                end else begin
                    o_ctl.cmd = CMD_START_EU;
                    n_cnt     = '0;
                    n_state   = S_RUN_A;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_ctl.cmd   = CMD_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= JOB_RED_A;
            r_src       <= SRC_ZERO;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_src       <= n_src;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.cmd == CMD_RESULT) |-> (!r_out_valid || i_rsp_ready))
        else $error("result written over an untaken response");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_START))
        else $error("accepted request did not start");

    a_step_b_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN_B) |-> ((r_job == JOB_MUL) || (r_job == JOB_EU)))
        else $error("add phase entered during a reduction");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("response raised outside the finish state");

endmodule

// ===== rtl/prime_field_mul_sqr_inv_unit.sv =====
// top level of the modular multiply, square and inverse unit
// Modular arithmetic unit over the modulus register (reset 2381327587, written
// through i_cfg_wr_en / i_cfg_wr_data; the user must write it only while idle,
// as the block does not enforce this). Each request carries an opcode
// (multiply a*b, square a*a, invert a) and two operands; each request yields
// exactly one response whose result is below the modulus. A modulus below 2 or
// the unused opcode gives 0. Operands are first reduced by a one-bit-per-cycle
// shift-subtract divider. Products use a modular double-and-add over the
// multiplier bits, a double step and then a conditional add step per bit. The
// inverse runs the extended Euclidean algorithm: each iteration is one W-step
// division (W = word width) whose quotient bits feed the same double-and-add to
// form q*nt mod m. A multiply reduces a and b first, a square reduces only a,
// and an inverse reduces a and then iterates until the remainder is zero. One
// request is in flight at a time; the response sits in an output register, so
// the next request is taken while the previous response waits.
module prime_field_mul_sqr_inv_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pfmsi_pkg::WORD_BITS-1:0] i_cfg_wr_data,
    pfmsi_req_if.sink                       i_req,
    pfmsi_rsp_if.source                     o_rsp
);
    import pfmsi_pkg::*;

    // modulus register, sampled by the datapath when a request is loaded
    logic [WORD_BITS-1:0] r_modulus;

    // controller/datapath link
    t_ctl ctl;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    // sequencer: decides which reduction, multiply or euclid step runs next
    pfmsi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // arithmetic: divider step, modular add/double, euclid registers, result register
    pfmsi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_modulus   (r_modulus),
        .i_opcode    (i_req.opcode),
        .i_operand_a (i_req.operand_a),
        .i_operand_b (i_req.operand_b),
        .o_sts       (sts),
        .o_result    (o_rsp.result)
    );

endmodule

// ===== tb/prime_field_mul_sqr_inv_unit_tb.sv =====
// self-checking testbench for the modular multiply, square and inverse unit
module prime_field_mul_sqr_inv_unit_tb;
    import pfmsi_pkg::*;

    // the limit allows every request to be a slowest-case inverse behind the
    // longest stalls, several times over
    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int LONG_HOLD     = 8000;
    localparam int DRAIN_CYCLES  = 3300;
    localparam int SETTLE_CYCLES = 8;

    // tracks the modulus register and the field results still owed by the unit
    class field_op_scoreboard;
        bit [WORD_BITS-1:0] modulus;
        bit [WORD_BITS-1:0] results_due[$];
        int                 mismatches;

        function new();
            modulus    = MOD_RESET;
            mismatches = 0;
        endfunction

        // extended euclid with the coefficient of x kept in [0, m)
        function bit [WORD_BITS-1:0] euclid_inverse(bit [63:0] x, bit [63:0] m);
            bit [63:0] r, nr, t, nt, q, rem, qt, tn;
            r  = m;
            nr = x;
            t  = '0;
            nt = 64'd1;
            while (nr != 0) begin
                q   = r / nr;
                rem = r - q * nr;
                qt  = ((q % m) * nt) % m;
                tn  = (t >= qt) ? (t - qt) : (t + (m - qt));
                t   = nt;
                nt  = tn;
                r   = nr;
                nr  = rem;
            end
            return t[WORD_BITS-1:0];
        endfunction

        function bit [WORD_BITS-1:0] field_result(t_op op, bit [WORD_BITS-1:0] a_in,
                                                  bit [WORD_BITS-1:0] b_in);
            bit [63:0] m, a, b, res;
            m   = {32'd0, modulus};
            res = '0;
            if (m >= 2) begin
                a = {32'd0, a_in} % m;
                b = {32'd0, b_in} % m;
                case (op)
                    OP_MUL:  res = (a * b) % m;
                    OP_SQR:  res = (a * a) % m;
                    OP_INV:  res = (a == 0) ? 64'd0 : {32'd0, euclid_inverse(a, m)};
                    default: res = '0;
                endcase
            end
            return res[WORD_BITS-1:0];
        endfunction

        function void note_request(t_op op, bit [WORD_BITS-1:0] a, bit [WORD_BITS-1:0] b);
            results_due.push_back(field_result(op, a, b));
        endfunction

        function void check_result(bit [WORD_BITS-1:0] got);
            bit [WORD_BITS-1:0] want;
            if (results_due.size() == 0) begin
                $error("result: expected none pending, actual %0d", got);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    $error("result: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [WORD_BITS-1:0] cfg_wr_data;

    pfmsi_req_if req_ch();
    pfmsi_rsp_if rsp_ch();

    field_op_scoreboard sb = new();

    // idling switch shared by both sides, and a request for one long response stall
    bit idle_on       = 1'b1;
    bit long_hold_req = 1'b0;
    int cycle_count   = 0;

    prime_field_mul_sqr_inv_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch.sink),
        .o_rsp         (rsp_ch.source)
    );

    // clock, period 4
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // observe both handshakes at the edge, before any driver update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(t_op'(req_ch.opcode), req_ch.operand_a, req_ch.operand_b);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.result);
        end
    end

    // response side: one ready update per cycle, with random stall bursts,
    // and a single long hold-off on request so the unit backs up into its input
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // after an occasional random pause while idling is on, offer one request and hold it
    // until the unit takes it; valid stays high afterwards so back-to-back requests need no gap
    task automatic send_request(t_op op, bit [WORD_BITS-1:0] a, bit [WORD_BITS-1:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // stop offering and wait for every owed result; waiting for a clock edge first lets the
    // last accepted request reach the scoreboard before the check
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.results_due.size() != 0) @(posedge i_clk);
    endtask

    // modulus writes only happen with the unit idle
    task automatic write_modulus(bit [WORD_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        sb.modulus = value;
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_op pick_op();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return OP_NONE;
        else if (roll <= 5)
            return OP_MUL;
        else if (roll <= 10)
            return OP_SQR;
        else
            return OP_INV;
    endfunction

    // operands lean on the edges around the current modulus
    function automatic bit [WORD_BITS-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 1;
            2:       return sb.modulus - 1;
            3:       return sb.modulus;
            4:       return sb.modulus + 1;
            5:       return '1;
            6:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // random phase; idling toggles now and then so quiet stretches appear too, or is held off when not allowed
    task automatic run_random(int count, bit allow_idle);
        for (int i = 0; i < count; i++) begin
            if (!allow_idle)
                idle_on = 1'b0;
            else if ($urandom_range(0, 59) == 0)
                idle_on = !idle_on;
            send_request(pick_op(), pick_operand(), pick_operand());
        end
    endtask

    initial begin
        bit [WORD_BITS-1:0] m;

        i_rst_n          <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= OP_MUL;
        req_ch.operand_a <= '0;
        req_ch.operand_b <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset modulus, operand extremes, unreduced operands,
        // zero inverse and the unused opcode
        m = MOD_RESET;
        send_request(OP_MUL,  '0, '0);
        send_request(OP_MUL,  '1, '1);
        send_request(OP_MUL,  m - 1, m - 1);
        send_request(OP_MUL,  m, 5);
        send_request(OP_MUL,  1, m + 1);
        send_request(OP_MUL,  32'hAAAA_AAAA, 32'h5555_5555);
        send_request(OP_SQR,  '1, '0);
        send_request(OP_SQR,  m - 1, '1);
        send_request(OP_SQR,  m, 7);
        send_request(OP_SQR,  32'h8000_0000, 32'h8000_0000);
        send_request(OP_INV,  '0, '1);
        send_request(OP_INV,  1, 0);
        send_request(OP_INV,  2, 0);
        send_request(OP_INV,  m - 1, 0);
        send_request(OP_INV,  m, 0);
        send_request(OP_INV,  m + 1, 0);
        send_request(OP_INV,  '1, 0);
        send_request(OP_NONE, '1, '1);
        send_request(OP_NONE, '0, '0);
        wait_drained();

        run_random(300, 1'b1);

        // backpressure: response side stalls while requests keep coming
        long_hold_req = 1'b1;
        run_random(30, 1'b1);
        wait_drained();
        run_random(170, 1'b1);

        // largest prime below 2^32
        write_modulus(32'hFFFF_FFFB);
        run_random(220, 1'b1);

        // largest modulus, composite, so some operands share a factor
        write_modulus('1);
        run_random(200, 1'b1);

        // smallest valid modulus
        write_modulus(2);
        run_random(80, 1'b1);

        // zero and unit modulus give 0 for everything
        write_modulus(0);
        send_request(OP_INV, '1, '1);
        run_random(40, 1'b1);
        write_modulus(1);
        send_request(OP_MUL, '1, '1);
        run_random(40, 1'b1);

        write_modulus(3);
        run_random(60, 1'b1);

        // small composite modulus, many non-invertible operands
        write_modulus(1_000_000);
        send_request(OP_INV, 250_000, 0);
        send_request(OP_INV, 1_000_002, 0);
        run_random(100, 1'b1);

        // arbitrary odd modulus with the top bit set
        write_modulus($urandom | 32'h8000_0001);
        run_random(80, 1'b1);

        // back to the reset value, last stretch with no idling on either side
        write_modulus(MOD_RESET);
        run_random(160, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pfmsi_pkg.sv
rtl/pfmsi_req_if.sv
rtl/pfmsi_rsp_if.sv
rtl/pfmsi_dp.sv
rtl/pfmsi_ctrl.sv
rtl/prime_field_mul_sqr_inv_unit.sv
tb/prime_field_mul_sqr_inv_unit_tb.sv
